/* rtl/core/cseg_pkg.sv */
// Shared constants, types and functions for the cone segment vertex generator.
// No dependencies; every other file uses this package by scoped names.
package cseg_pkg;

    // Segment count clamp and CORDIC defaults
    localparam int MAX_SEGMENTS     = 4096;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_MAX_STEPS = 31;

    // Field widths
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int CFG_A_W = 3;

    // CORDIC start value, 0.6072529350 in Q2.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Corner numbering
    localparam logic [2:0] CORNER_APEX   = 3'd0;
    localparam logic [2:0] CORNER_RIM0_A = 3'd1;
    localparam logic [2:0] CORNER_RIM1_A = 3'd2;
    localparam logic [2:0] CORNER_BASE   = 3'd3;
    localparam logic [2:0] CORNER_RIM0_B = 3'd4;
    localparam logic [2:0] CORNER_LAST   = 3'd5;

    // Configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        REG_SEGMENT_COUNT = 3'd0,
        REG_CONE_HEIGHT   = 3'd1,
        REG_CONE_RADIUS   = 3'd2,
        REG_ORIGIN_X      = 3'd3,
        REG_ORIGIN_Y      = 3'd4,
        REG_ORIGIN_Z      = 3'd5
    } cfg_reg_t;

    // One CORDIC lane state
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
    } cordic_t;

    // Arctangent of 2^-k as a fraction of a full turn, 2^32 scale
    function automatic logic signed [32:0] atan_turn(input int k);
        logic signed [32:0] a;
        case (k)
            0:  a = 33'sd536870912;
            1:  a = 33'sd316933406;
            2:  a = 33'sd167458907;
            3:  a = 33'sd85004756;
            4:  a = 33'sd42667331;
            5:  a = 33'sd21354465;
            6:  a = 33'sd10679838;
            7:  a = 33'sd5340245;
            8:  a = 33'sd2670163;
            9:  a = 33'sd1335087;
            10: a = 33'sd667544;
            11: a = 33'sd333772;
            12: a = 33'sd166886;
            13: a = 33'sd83443;
            14: a = 33'sd41722;
            15: a = 33'sd20861;
            16: a = 33'sd10430;
            17: a = 33'sd5215;
            18: a = 33'sd2608;
            19: a = 33'sd1304;
            20: a = 33'sd652;
            21: a = 33'sd326;
            22: a = 33'sd163;
            23: a = 33'sd81;
            24: a = 33'sd41;
            25: a = 33'sd20;
            26: a = 33'sd10;
            27: a = 33'sd5;
            28: a = 33'sd3;
            default: a = 33'sd1;
        endcase
        return a;
    endfunction

    // One rotation-mode CORDIC iteration at a fixed shift
    function automatic cordic_t cordic_step(input cordic_t c, input int k);
        cordic_t r;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        dx = c.y >>> k;
        dy = c.x >>> k;
        if (c.z >= 0)
        begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.z = c.z - atan_turn(k);
        end
        else
        begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.z = c.z + atan_turn(k);
        end
        return r;
    endfunction

    // Clamp a 35-bit sum to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* rtl/core/cseg_if.sv */
// Channel interfaces: segment input, vertex output and configuration write.
// Depends on cseg_pkg for field widths.
interface cseg_in_if;
    logic                          valid;
    logic                          ready;
    logic [cseg_pkg::IDX_W-1:0]    segment_index;
    modport source (output valid, output segment_index, input ready);
    modport sink   (input valid, input segment_index, output ready);
endinterface

interface cseg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [cseg_pkg::COORD_W-1:0] vertex_x;
    logic signed [cseg_pkg::COORD_W-1:0] vertex_y;
    logic signed [cseg_pkg::COORD_W-1:0] vertex_z;
    logic [2:0]                          corner_number;
    logic                                last_of_segment;
    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    output corner_number, output last_of_segment, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    input corner_number, input last_of_segment, output ready);
endinterface

interface cseg_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cseg_pkg::CFG_A_W-1:0]  index;
    logic [31:0]                   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/cone_segment_vertex_generator.sv */
// Pipeline: 3 mod + 8 divide + CORDIC_STEPS + 3 stages, then the output buffer.
// Throughput: the six-beat output buffer holds one segment and takes the next only
// once its last beat is accepted; the pipeline takes a new index every cycle
// while stages ahead have room.
// Reset: rst_n clears all stage valids and the output buffer, config to defaults.
// Depends on cseg_pkg and the channel interfaces in cseg_if.sv.
module cone_segment_vertex_generator #(
    parameter int CORDIC_STEPS = cseg_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    cseg_in_if.sink      seg_in,
    cseg_out_if.source   vtx_out,
    cseg_cfg_if.sink     cfg
);

    localparam int NSTEP = (CORDIC_STEPS > cseg_pkg::CORDIC_MAX_STEPS) ?
                           cseg_pkg::CORDIC_MAX_STEPS : CORDIC_STEPS;
    localparam int MS = 3;            // modulo stages, 4 bits each
    localparam int DS = 8;            // phase divide stages, 4 bits each
    localparam int CS = NSTEP;        // CORDIC stages
    localparam int QI = MS + DS + CS; // quadrant fold
    localparam int MI = QI + 1;       // radius multiply
    localparam int SI = QI + 2;       // round, offset, saturate
    localparam int NS = SI + 1;

    // Configuration registers
    logic [12:0]        seg_count_reg;
    logic signed [31:0] height_reg;
    logic [30:0]        radius_reg;
    logic signed [31:0] org_x_reg;
    logic signed [31:0] org_y_reg;
    logic signed [31:0] org_z_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= 13'd32;
            height_reg    <= 32'sd65536;
            radius_reg    <= 31'd65536;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            org_z_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cseg_pkg::cfg_reg_t'(cfg.index))
                cseg_pkg::REG_SEGMENT_COUNT: seg_count_reg <= cfg.data[12:0];
                cseg_pkg::REG_CONE_HEIGHT:   height_reg    <= cfg.data;
                cseg_pkg::REG_CONE_RADIUS:   radius_reg    <= cfg.data[30:0];
                cseg_pkg::REG_ORIGIN_X:      org_x_reg     <= cfg.data;
                cseg_pkg::REG_ORIGIN_Y:      org_y_reg     <= cfg.data;
                cseg_pkg::REG_ORIGIN_Z:      org_z_reg     <= cfg.data;
                default: ;
            endcase
        end
    end

    // Effective segment count, clamped to 1..MAX_SEGMENTS
    logic [12:0] n;
    always_comb
    begin
        if (seg_count_reg == 13'd0)
            n = 13'd1;
        else if ({19'd0, seg_count_reg} > 32'(cseg_pkg::MAX_SEGMENTS))
            n = 13'(cseg_pkg::MAX_SEGMENTS);
        else
            n = seg_count_reg;
    end

    // Stage valids and stall chain; a stage moves when it is empty or the next moves
    logic [NS-1:0] v_reg;
    logic [NS:0]   en;
    logic [2:0]    cnt_reg;
    logic          ob_v_reg;

    always_comb
    begin
        en[NS] = !ob_v_reg || (vtx_out.ready && cnt_reg == cseg_pkg::CORNER_LAST);
        for (int i = NS - 1; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    assign seg_in.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= seg_in.valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    // Index mod n, restoring remainder, MSB first
    logic [12:0] mr_reg [MS];
    logic [11:0] mi_reg [MS];

    for (genvar g = 0; g < MS; g++)
    begin : g_mod
        logic [12:0] r_src;
        logic [11:0] i_src;
        logic [12:0] r_nxt;
        logic [11:0] i_nxt;
        if (g == 0)
        begin : g_first
            assign r_src = '0;
            assign i_src = seg_in.segment_index;
        end
        else
        begin : g_rest
            assign r_src = mr_reg[g-1];
            assign i_src = mi_reg[g-1];
        end
        always_comb
        begin
            logic [13:0] t;
            r_nxt = r_src;
            i_nxt = i_src;
            for (int j = 0; j < 4; j++)
            begin
                t = {r_nxt, i_nxt[11]};
                i_nxt = {i_nxt[10:0], 1'b0};
                r_nxt = (t >= {1'b0, n}) ? 13'(t - {1'b0, n}) : 13'(t);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                mr_reg[g] <= r_nxt;
                mi_reg[g] <= i_nxt;
            end
        end
    end

    // Next angle index, wrapping to zero at n
    logic [13:0] k1_inc;
    logic [12:0] k1;
    assign k1_inc = {1'b0, mr_reg[MS-1]} + 14'd1;
    assign k1     = (k1_inc == {1'b0, n}) ? 13'd0 : k1_inc[12:0];

    // Phase = floor(k * 2^32 / n), two lanes, long division
    logic [12:0] dr0_reg [DS];
    logic [12:0] dr1_reg [DS];
    logic [31:0] dq0_reg [DS];
    logic [31:0] dq1_reg [DS];

    for (genvar g = 0; g < DS; g++)
    begin : g_div
        logic [12:0] r0_src, r1_src, r0_nxt, r1_nxt;
        logic [31:0] q0_src, q1_src, q0_nxt, q1_nxt;
        if (g == 0)
        begin : g_first
            assign r0_src = mr_reg[MS-1];
            assign r1_src = k1;
            assign q0_src = '0;
            assign q1_src = '0;
        end
        else
        begin : g_rest
            assign r0_src = dr0_reg[g-1];
            assign r1_src = dr1_reg[g-1];
            assign q0_src = dq0_reg[g-1];
            assign q1_src = dq1_reg[g-1];
        end
        always_comb
        begin
            logic [13:0] t0;
            logic [13:0] t1;
            r0_nxt = r0_src;
            r1_nxt = r1_src;
            q0_nxt = q0_src;
            q1_nxt = q1_src;
            for (int j = 0; j < 4; j++)
            begin
                t0 = {r0_nxt, 1'b0};
                t1 = {r1_nxt, 1'b0};
                q0_nxt = {q0_nxt[30:0], t0 >= {1'b0, n}};
                q1_nxt = {q1_nxt[30:0], t1 >= {1'b0, n}};
                r0_nxt = (t0 >= {1'b0, n}) ? 13'(t0 - {1'b0, n}) : 13'(t0);
                r1_nxt = (t1 >= {1'b0, n}) ? 13'(t1 - {1'b0, n}) : 13'(t1);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en[MS+g])
            begin
                dr0_reg[g] <= r0_nxt;
                dr1_reg[g] <= r1_nxt;
                dq0_reg[g] <= q0_nxt;
                dq1_reg[g] <= q1_nxt;
            end
        end
    end

    // CORDIC, one iteration per stage, quadrant bits ride along
    cseg_pkg::cordic_t c0_reg [CS];
    cseg_pkg::cordic_t c1_reg [CS];
    logic [1:0]        qd0_reg [CS];
    logic [1:0]        qd1_reg [CS];

    for (genvar g = 0; g < CS; g++)
    begin : g_cordic
        cseg_pkg::cordic_t c0_src, c1_src;
        logic [1:0]        q0_src, q1_src;
        if (g == 0)
        begin : g_first
            assign c0_src = '{x: cseg_pkg::CORDIC_GAIN, y: '0,
                              z: {3'b000, dq0_reg[DS-1][29:0]}};
            assign c1_src = '{x: cseg_pkg::CORDIC_GAIN, y: '0,
                              z: {3'b000, dq1_reg[DS-1][29:0]}};
            assign q0_src = dq0_reg[DS-1][31:30];
            assign q1_src = dq1_reg[DS-1][31:30];
        end
        else
        begin : g_rest
            assign c0_src = c0_reg[g-1];
            assign c1_src = c1_reg[g-1];
            assign q0_src = qd0_reg[g-1];
            assign q1_src = qd1_reg[g-1];
        end
        always_ff @(posedge clk)
        begin
            if (en[MS+DS+g])
            begin
                c0_reg[g]  <= cseg_pkg::cordic_step(c0_src, g);
                c1_reg[g]  <= cseg_pkg::cordic_step(c1_src, g);
                qd0_reg[g] <= q0_src;
                qd1_reg[g] <= q1_src;
            end
        end
    end

    // Quadrant fold to cos/sin
    logic signed [31:0] tc0_reg, ts0_reg, tc1_reg, ts1_reg;

    function automatic logic signed [63:0] fold(input cseg_pkg::cordic_t c,
                                                input logic [1:0] q);
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] co;
        logic signed [31:0] si;
        x = c.x[31:0];
        y = c.y[31:0];
        case (q)
            2'd0:    begin co = x;  si = y;  end
            2'd1:    begin co = -y; si = x;  end
            2'd2:    begin co = -x; si = -y; end
            default: begin co = y;  si = -x; end
        endcase
        return {co, si};
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[QI])
        begin
            {tc0_reg, ts0_reg} <= fold(c0_reg[CS-1], qd0_reg[CS-1]);
            {tc1_reg, ts1_reg} <= fold(c1_reg[CS-1], qd1_reg[CS-1]);
        end
    end

    // Radius multiply
    logic signed [63:0] py0_reg, pz0_reg, py1_reg, pz1_reg;
    logic signed [31:0] rad_s;
    assign rad_s = {1'b0, radius_reg};

    always_ff @(posedge clk)
    begin
        if (en[MI])
        begin
            py0_reg <= rad_s * tc0_reg;
            pz0_reg <= rad_s * ts0_reg;
            py1_reg <= rad_s * tc1_reg;
            pz1_reg <= rad_s * ts1_reg;
        end
    end

    // Round to Q16.16, add origin, saturate
    function automatic logic signed [31:0] place(input logic signed [63:0] p,
                                                 input logic signed [31:0] o);
        logic signed [63:0] rp;
        rp = (p + 64'sd536870912) >>> 30;
        return cseg_pkg::sat32(35'(o) + 35'($signed(rp[33:0])));
    endfunction

    logic signed [31:0] ry0_reg, rz0_reg, ry1_reg, rz1_reg;

    always_ff @(posedge clk)
    begin
        if (en[SI])
        begin
            ry0_reg <= place(py0_reg, org_y_reg);
            rz0_reg <= place(pz0_reg, org_z_reg);
            ry1_reg <= place(py1_reg, org_y_reg);
            rz1_reg <= place(pz1_reg, org_z_reg);
        end
    end

    // Output buffer: one segment, six beats
    logic signed [31:0] oy0_reg, oz0_reg, oy1_reg, oz1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_v_reg <= 1'b0;
            cnt_reg  <= cseg_pkg::CORNER_APEX;
        end
        else if (en[NS])
        begin
            ob_v_reg <= v_reg[NS-1];
            cnt_reg  <= cseg_pkg::CORNER_APEX;
        end
        else if (vtx_out.ready)
            cnt_reg <= cnt_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en[NS])
        begin
            oy0_reg <= ry0_reg;
            oz0_reg <= rz0_reg;
            oy1_reg <= ry1_reg;
            oz1_reg <= rz1_reg;
        end
    end

    // Beat payload select
    logic signed [31:0] apex_x;
    assign apex_x = cseg_pkg::sat32(35'(org_x_reg) + 35'(height_reg));

    always_comb
    begin
        vtx_out.vertex_x = org_x_reg;
        vtx_out.vertex_y = org_y_reg;
        vtx_out.vertex_z = org_z_reg;
        case (cnt_reg) inside
            cseg_pkg::CORNER_APEX:
                vtx_out.vertex_x = apex_x;
            cseg_pkg::CORNER_RIM0_A, cseg_pkg::CORNER_RIM0_B:
            begin
                vtx_out.vertex_y = oy0_reg;
                vtx_out.vertex_z = oz0_reg;
            end
            cseg_pkg::CORNER_RIM1_A, cseg_pkg::CORNER_LAST:
            begin
                vtx_out.vertex_y = oy1_reg;
                vtx_out.vertex_z = oz1_reg;
            end
            default: ;
        endcase
    end

    assign vtx_out.valid           = ob_v_reg;
    assign vtx_out.corner_number   = cnt_reg;
    assign vtx_out.last_of_segment = (cnt_reg == cseg_pkg::CORNER_LAST);

endmodule

/* rtl/core/cseg_checker.sv */
// Port-level assertions for the cone segment vertex generator, bound to the top.
// Depends on cseg_pkg and cone_segment_vertex_generator.
module cseg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] corner,
    input logic       last
);

    // Corner stays within one segment
    a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> corner <= cseg_pkg::CORNER_LAST)
        else $error("corner number out of range");

    // Last flag marks exactly the sixth beat
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (corner == cseg_pkg::CORNER_LAST)))
        else $error("last_of_segment mismatch");

    // Within a segment the next beat follows immediately with the next corner
    a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && corner != cseg_pkg::CORNER_LAST)
        |=> (out_valid && corner == $past(corner) + 3'd1))
        else $error("corner sequence broken");

    // Stalled beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(corner)))
        else $error("stalled beat changed");

endmodule

bind cone_segment_vertex_generator cseg_checker u_cseg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (vtx_out.valid),
    .out_ready (vtx_out.ready),
    .corner    (vtx_out.corner_number),
    .last      (vtx_out.last_of_segment)
);

/* sim/tb.sv */
// Testbench for cone_segment_vertex_generator: drives segment indexes and register
// writes, predicts the six vertices of each segment and checks every output beat.
// Depends on cseg_pkg, the channel interfaces and the block itself.
module tb;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [2:0]         corner;
        logic               last;
    } vertex_t;

    typedef struct {
        bit               is_cfg;
        cseg_pkg::cfg_reg_t reg_id;
        logic [31:0]      data;
        logic [11:0]      idx;
    } job_t;

    logic clk;
    logic rst_n;
    int   in_idle_pct;
    int   out_idle_pct;
    int   fail_count;
    bit   done;

    cseg_in_if  seg_in ();
    cseg_out_if vtx_out ();
    cseg_cfg_if cfg ();

    cone_segment_vertex_generator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_in  (seg_in),
        .vtx_out (vtx_out),
        .cfg     (cfg)
    );

    // Predictor copy of the registers
    logic [12:0]        p_count;
    logic signed [31:0] p_height;
    logic [30:0]        p_radius;
    logic signed [31:0] p_ox;
    logic signed [31:0] p_oy;
    logic signed [31:0] p_oz;

    job_t    pending_jobs[$];
    vertex_t expected_vertices[$];

    always #2 clk = ~clk;

    function automatic logic signed [63:0] asr(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Rotation-mode sine/cosine of a turn fraction, Q2.30
    task automatic phase_trig(input logic [31:0] phase, output logic signed [63:0] c,
                              output logic signed [63:0] s);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        int k;
        x = 64'sd652032874;
        y = 0;
        z = {34'd0, phase[29:0]};
        for (k = 0; k < 16; k++)
        begin
            dx = asr(y, k);
            dy = asr(x, k);
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - cseg_pkg::atan_turn(k);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + cseg_pkg::atan_turn(k);
            end
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic logic signed [63:0] radius_times(input logic signed [63:0] t);
        logic signed [63:0] p;
        p = $signed({33'd0, p_radius}) * t;
        return asr(p + (64'sd1 <<< 29), 30);
    endfunction

    task automatic rim_at(input logic [63:0] k, input logic [63:0] n,
                          output logic signed [31:0] y, output logic signed [31:0] z);
        logic [63:0]        ph;
        logic signed [63:0] c;
        logic signed [63:0] s;
        ph = (k << 32) / n;
        phase_trig(ph[31:0], c, s);
        y = clamp32(64'(p_oy) + radius_times(c));
        z = clamp32(64'(p_oz) + radius_times(s));
    endtask

    task automatic predict_segment(input logic [11:0] idx);
        logic [63:0]        n;
        logic [63:0]        k0;
        logic [63:0]        k1;
        logic signed [31:0] y0, z0, y1, z1;
        logic signed [31:0] ax;
        vertex_t            v;
        n = p_count;
        if (n == 0)
            n = 1;
        if (n > cseg_pkg::MAX_SEGMENTS)
            n = cseg_pkg::MAX_SEGMENTS;
        k0 = idx % n;
        k1 = (k0 + 1) % n;
        rim_at(k0, n, y0, z0);
        rim_at(k1, n, y1, z1);
        ax = clamp32(64'(p_ox) + 64'(p_height));
        v.last = 1'b0;
        v.corner = cseg_pkg::CORNER_APEX;   v.vx = ax;   v.vy = p_oy; v.vz = p_oz;
        expected_vertices.push_back(v);
        v.corner = cseg_pkg::CORNER_RIM0_A; v.vx = p_ox; v.vy = y0;   v.vz = z0;
        expected_vertices.push_back(v);
        v.corner = cseg_pkg::CORNER_RIM1_A; v.vy = y1;   v.vz = z1;
        expected_vertices.push_back(v);
        v.corner = cseg_pkg::CORNER_BASE;   v.vy = p_oy; v.vz = p_oz;
        expected_vertices.push_back(v);
        v.corner = cseg_pkg::CORNER_RIM0_B; v.vy = y0;   v.vz = z0;
        expected_vertices.push_back(v);
        v.corner = cseg_pkg::CORNER_LAST;   v.vy = y1;   v.vz = z1;   v.last = 1'b1;
        expected_vertices.push_back(v);
    endtask

    task automatic apply_reg(input cseg_pkg::cfg_reg_t r, input logic [31:0] d);
        case (r)
            cseg_pkg::REG_SEGMENT_COUNT: p_count  = d[12:0];
            cseg_pkg::REG_CONE_HEIGHT:   p_height = d;
            cseg_pkg::REG_CONE_RADIUS:   p_radius = d[30:0];
            cseg_pkg::REG_ORIGIN_X:      p_ox     = d;
            cseg_pkg::REG_ORIGIN_Y:      p_oy     = d;
            default:                     p_oz     = d;
        endcase
    endtask

    // Driver: config beats go out only when the block is drained
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (seg_in.valid && seg_in.ready)
            begin
                predict_segment(seg_in.segment_index);
                void'(pending_jobs.pop_front());
            end
            if (cfg.valid && cfg.ready)
            begin
                apply_reg(cseg_pkg::cfg_reg_t'(cfg.index), cfg.data);
                void'(pending_jobs.pop_front());
            end
            if (pending_jobs.size() > 0 && !(seg_in.valid && !seg_in.ready)
                && !(cfg.valid && !cfg.ready))
            begin
                if (pending_jobs[0].is_cfg)
                begin
                    seg_in.valid <= 1'b0;
                    cfg.valid    <= 1'b1;
                    cfg.index    <= pending_jobs[0].reg_id;
                    cfg.data     <= pending_jobs[0].data;
                end
                else
                begin
                    cfg.valid <= 1'b0;
                    if ($urandom_range(99) < in_idle_pct)
                        seg_in.valid <= 1'b0;
                    else
                    begin
                        seg_in.valid         <= 1'b1;
                        seg_in.segment_index <= pending_jobs[0].idx;
                    end
                end
            end
            else if (pending_jobs.size() == 0)
            begin
                seg_in.valid <= 1'b0;
                cfg.valid    <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall
    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n)
        begin
            if (vtx_out.valid && vtx_out.ready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    $error("vertex beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = expected_vertices.pop_front();
                    if (vtx_out.vertex_x !== e.vx)
                    begin
                        $error("vertex_x exp %0d got %0d", e.vx, vtx_out.vertex_x);
                        fail_count++;
                    end
                    if (vtx_out.vertex_y !== e.vy)
                    begin
                        $error("vertex_y exp %0d got %0d", e.vy, vtx_out.vertex_y);
                        fail_count++;
                    end
                    if (vtx_out.vertex_z !== e.vz)
                    begin
                        $error("vertex_z exp %0d got %0d", e.vz, vtx_out.vertex_z);
                        fail_count++;
                    end
                    if (vtx_out.corner_number !== e.corner)
                    begin
                        $error("corner_number exp %0d got %0d", e.corner,
                               vtx_out.corner_number);
                        fail_count++;
                    end
                    if (vtx_out.last_of_segment !== e.last)
                    begin
                        $error("last_of_segment exp %0d got %0d", e.last,
                               vtx_out.last_of_segment);
                        fail_count++;
                    end
                end
            end
            vtx_out.ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    task automatic queue_seg(input logic [11:0] idx);
        job_t j;
        j.is_cfg = 0;
        j.idx    = idx;
        pending_jobs.push_back(j);
    endtask

    // Register write, queued for the driver once drained
    task automatic write_reg(input cseg_pkg::cfg_reg_t r, input logic [31:0] d);
        job_t j;
        j.is_cfg = 1;
        j.reg_id = r;
        j.data   = d;
        while (pending_jobs.size() > 0 || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        pending_jobs.push_back(j);
        while (pending_jobs.size() > 0)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_jobs.size() > 0 || expected_vertices.size() > 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int items, input int max_idx);
        int i;
        for (i = 0; i < items; i++)
        begin
            if ($urandom_range(9) == 0)
                queue_seg(12'($urandom));
            else
                queue_seg(12'($urandom_range(max_idx)));
        end
        wait_drained();
    endtask

    initial
    begin
        int i;
        clk = 0;
        rst_n = 0;
        done = 0;
        fail_count = 0;
        in_idle_pct = 28;
        out_idle_pct = 74;
        seg_in.valid = 0;
        seg_in.segment_index = '0;
        vtx_out.ready = 0;
        cfg.valid = 0;
        cfg.index = '0;
        cfg.data = '0;
        p_count = 13'd32;
        p_height = 32'sd65536;
        p_radius = 31'd65536;
        p_ox = 0;
        p_oy = 0;
        p_oz = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: defaults, index extremes, wrap past count, last segment
        queue_seg(12'd0);
        queue_seg(12'd31);
        queue_seg(12'd32);
        queue_seg(12'hFFF);
        queue_seg(12'd8);
        queue_seg(12'd16);
        queue_seg(12'd24);
        wait_drained();
        // Segment count zero acts as one
        write_reg(cseg_pkg::REG_SEGMENT_COUNT, 32'd0);
        queue_seg(12'd0);
        queue_seg(12'hABC);
        wait_drained();
        // Count above the clamp, saturating extremes of origin and size
        write_reg(cseg_pkg::REG_SEGMENT_COUNT, 32'h1FFF);
        write_reg(cseg_pkg::REG_CONE_HEIGHT, 32'h7FFFFFFF);
        write_reg(cseg_pkg::REG_CONE_RADIUS, 32'h7FFFFFFF);
        write_reg(cseg_pkg::REG_ORIGIN_X, 32'h7FFFFFFF);
        write_reg(cseg_pkg::REG_ORIGIN_Y, 32'h7FFFFFFF);
        write_reg(cseg_pkg::REG_ORIGIN_Z, 32'h80000000);
        queue_seg(12'd0);
        queue_seg(12'd1024);
        queue_seg(12'd2048);
        queue_seg(12'd3072);
        queue_seg(12'hFFF);
        queue_seg(12'd555);
        wait_drained();
        write_reg(cseg_pkg::REG_CONE_HEIGHT, 32'h80000000);
        write_reg(cseg_pkg::REG_ORIGIN_X, 32'h80000000);
        write_reg(cseg_pkg::REG_ORIGIN_Y, 32'h80000000);
        write_reg(cseg_pkg::REG_ORIGIN_Z, 32'h7FFFFFFF);
        write_reg(cseg_pkg::REG_SEGMENT_COUNT, 32'd3);
        queue_seg(12'd0);
        queue_seg(12'd1);
        queue_seg(12'd2);
        queue_seg(12'd5);
        wait_drained();

        // Random phases with fresh settings; idling pattern swaps, then idling stops for the last two
        for (i = 0; i < 6; i++)
        begin
            if (i == 2)
            begin
                in_idle_pct = 74;
                out_idle_pct = 28;
            end
            if (i == 4)
            begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            write_reg(cseg_pkg::REG_SEGMENT_COUNT, $urandom_range(4200, 1));
            write_reg(cseg_pkg::REG_CONE_HEIGHT, $urandom);
            write_reg(cseg_pkg::REG_CONE_RADIUS, (i % 2) ? $urandom : $urandom_range(1 << 22));
            write_reg(cseg_pkg::REG_ORIGIN_X, $urandom);
            write_reg(cseg_pkg::REG_ORIGIN_Y, (i % 2) ? $urandom : $urandom_range(1 << 24));
            write_reg(cseg_pkg::REG_ORIGIN_Z, (i % 2) ? $urandom : $urandom_range(1 << 24));
            random_phase(80, (p_count == 0) ? 0 : ((p_count > 4095) ? 4095 : p_count - 1));
        end

        repeat (60) @(posedge clk);
        done = 1;
        if (fail_count == 0 && expected_vertices.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        if (!done)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
